[design/rvde_pkg.sv]
// Shared types, opcode codes and function codes for the RV32I decode and execute block.
// Used by rvde_decode, rvde_alu, rvde_exec and rv32i_decode_execute; depends on nothing.
package rvde_pkg;

   localparam int XLEN       = 32;
   localparam int REG_IDX_W  = 5;
   localparam int F3_W       = 3;
   localparam int OPC_W      = 7;
   localparam int MEM_KIND_W = 2;
   localparam int SHAMT_W    = 5;

   // Major opcodes (instr[6:0]).
   localparam logic [OPC_W-1:0] OPC_LUI    = 7'h37;
   localparam logic [OPC_W-1:0] OPC_AUIPC  = 7'h17;
   localparam logic [OPC_W-1:0] OPC_JAL    = 7'h6F;
   localparam logic [OPC_W-1:0] OPC_JALR   = 7'h67;
   localparam logic [OPC_W-1:0] OPC_BRANCH = 7'h63;
   localparam logic [OPC_W-1:0] OPC_LOAD   = 7'h03;
   localparam logic [OPC_W-1:0] OPC_STORE  = 7'h23;
   localparam logic [OPC_W-1:0] OPC_OPIMM  = 7'h13;
   localparam logic [OPC_W-1:0] OPC_OP     = 7'h33;

   // ALU function codes (funct3).
   localparam logic [F3_W-1:0] F3_ADD  = 3'd0;
   localparam logic [F3_W-1:0] F3_SLL  = 3'd1;
   localparam logic [F3_W-1:0] F3_SLT  = 3'd2;
   localparam logic [F3_W-1:0] F3_SLTU = 3'd3;
   localparam logic [F3_W-1:0] F3_XOR  = 3'd4;
   localparam logic [F3_W-1:0] F3_SR   = 3'd5;
   localparam logic [F3_W-1:0] F3_OR   = 3'd6;
   localparam logic [F3_W-1:0] F3_AND  = 3'd7;

   // Branch conditions (funct3).
   localparam logic [F3_W-1:0] F3_BEQ  = 3'd0;
   localparam logic [F3_W-1:0] F3_BNE  = 3'd1;
   localparam logic [F3_W-1:0] F3_BLT  = 3'd4;
   localparam logic [F3_W-1:0] F3_BGE  = 3'd5;
   localparam logic [F3_W-1:0] F3_BLTU = 3'd6;
   localparam logic [F3_W-1:0] F3_BGEU = 3'd7;

   // Memory access kinds.
   localparam logic [MEM_KIND_W-1:0] MEM_NONE  = 2'd0;
   localparam logic [MEM_KIND_W-1:0] MEM_LOAD  = 2'd1;
   localparam logic [MEM_KIND_W-1:0] MEM_STORE = 2'd2;

   typedef enum logic [3:0] {
      CLS_LUI,
      CLS_AUIPC,
      CLS_JAL,
      CLS_JALR,
      CLS_BRANCH,
      CLS_LOAD,
      CLS_STORE,
      CLS_OPIMM,
      CLS_OP,
      CLS_ILLEGAL
   } op_class_type;

   // Decoded instruction fields.
   typedef struct packed {
      op_class_type         op_class;
      logic [REG_IDX_W-1:0] rd;
      logic [F3_W-1:0]      funct3;
      logic                 alt;
      logic [XLEN-1:0]      imm_i;
      logic [XLEN-1:0]      imm_s;
      logic [XLEN-1:0]      imm_b;
      logic [XLEN-1:0]      imm_u;
      logic [XLEN-1:0]      imm_j;
   } decode_type;

   // One result beat.
   typedef struct packed {
      logic                  illegal;
      logic [XLEN-1:0]       store_data;
      logic [XLEN-1:0]       mem_addr;
      logic [F3_W-1:0]       mem_width;
      logic [MEM_KIND_W-1:0] mem_kind;
      logic                  branch_taken;
      logic [XLEN-1:0]       next_pc;
      logic [XLEN-1:0]       rd_data;
      logic                  rd_write;
      logic [REG_IDX_W-1:0]  rd_index;
   } result_type;

endpackage

[design/rvde_decode.sv]
// Instruction decoder: opcode class, register and function fields, immediates.
// Depends on rvde_pkg.
module rvde_decode
   import rvde_pkg::*;
(
   input  logic [XLEN-1:0] instr,
   output decode_type      dec
);

   // Sort the opcode into a class and pull out the sign-extended immediates.
   always_comb begin
      unique case (instr[OPC_W-1:0])
         OPC_LUI:    dec.op_class = CLS_LUI;
         OPC_AUIPC:  dec.op_class = CLS_AUIPC;
         OPC_JAL:    dec.op_class = CLS_JAL;
         OPC_JALR:   dec.op_class = CLS_JALR;
         OPC_BRANCH: dec.op_class = CLS_BRANCH;
         OPC_LOAD:   dec.op_class = CLS_LOAD;
         OPC_STORE:  dec.op_class = CLS_STORE;
         OPC_OPIMM:  dec.op_class = CLS_OPIMM;
         OPC_OP:     dec.op_class = CLS_OP;
         default:    dec.op_class = CLS_ILLEGAL;
      endcase
      dec.rd     = instr[11:7];
      dec.funct3 = instr[14:12];
      dec.alt    = instr[30];
      dec.imm_i  = {{20{instr[31]}}, instr[31:20]};
      dec.imm_s  = {{20{instr[31]}}, instr[31:25], instr[11:7]};
      dec.imm_b  = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
      dec.imm_u  = {instr[31:12], 12'b0};
      dec.imm_j  = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
   end

endmodule

[design/rvde_alu.sv]
// Integer ALU shared by the register and immediate operations.
// Depends on rvde_pkg.
module rvde_alu
   import rvde_pkg::*;
(
   input  logic [F3_W-1:0] funct3,
   input  logic            alt,
   input  logic            is_reg,
   input  logic [XLEN-1:0] op_a,
   input  logic [XLEN-1:0] op_b,
   output logic [XLEN-1:0] result
);

   logic [SHAMT_W-1:0] shamt;

   assign shamt = op_b[SHAMT_W-1:0];

   // Subtract only for the register form; instr[30] selects an arithmetic rather than a logical right shift.
   always_comb begin
      unique case (funct3)
         F3_ADD:  result = (is_reg && alt) ? op_a - op_b : op_a + op_b;
         F3_SLL:  result = op_a << shamt;
         F3_SLT:  result = {{(XLEN-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
         F3_SLTU: result = {{(XLEN-1){1'b0}}, (op_a < op_b)};
         F3_XOR:  result = op_a ^ op_b;
         F3_SR:   result = alt ? XLEN'($signed(op_a) >>> shamt) : op_a >> shamt;
         F3_OR:   result = op_a | op_b;
         F3_AND:  result = op_a & op_b;
         default: result = op_a & op_b;
      endcase
   end

endmodule

[design/rvde_exec.sv]
// Execute logic: combines decode, ALU, branch compare and address adders into one result.
// Depends on rvde_pkg, rvde_decode and rvde_alu.
module rvde_exec
   import rvde_pkg::*;
(
   input  logic [XLEN-1:0] instr,
   input  logic [XLEN-1:0] pc,
   input  logic [XLEN-1:0] rs1_value,
   input  logic [XLEN-1:0] rs2_value,
   output result_type      res
);

   decode_type      dec;
   logic [XLEN-1:0] alu_b;
   logic [XLEN-1:0] alu_out;
   logic [XLEN-1:0] pc_plus4;
   logic            cond;
   logic [XLEN-1:0] wr_data;
   logic            wr_en;

   rvde_decode u_decode (
      .instr (instr),
      .dec   (dec)
   );

   assign alu_b    = (dec.op_class == CLS_OP) ? rs2_value : dec.imm_i;
   assign pc_plus4 = pc + XLEN'(4);

   rvde_alu u_alu (
      .funct3 (dec.funct3),
      .alt    (dec.alt),
      .is_reg (dec.op_class == CLS_OP),
      .op_a   (rs1_value),
      .op_b   (alu_b),
      .result (alu_out)
   );

   // Branch condition; the two unused funct3 codes never branch.
   always_comb begin
      unique case (dec.funct3)
         F3_BEQ:  cond = (rs1_value == rs2_value);
         F3_BNE:  cond = (rs1_value != rs2_value);
         F3_BLT:  cond = ($signed(rs1_value) < $signed(rs2_value));
         F3_BGE:  cond = !($signed(rs1_value) < $signed(rs2_value));
         F3_BLTU: cond = (rs1_value < rs2_value);
         F3_BGEU: cond = (rs1_value >= rs2_value);
         default: cond = 1'b0;
      endcase
   end

   // Per-class result; rd is dropped when it is x0.
   always_comb begin
      res            = '0;
      res.next_pc    = pc_plus4;
      wr_data        = '0;
      wr_en          = 1'b0;
      unique case (dec.op_class)
         CLS_LUI: begin
            res.rd_index = dec.rd;
            wr_en        = 1'b1;
            wr_data      = dec.imm_u;
         end
         CLS_AUIPC: begin
            res.rd_index = dec.rd;
            wr_en        = 1'b1;
            wr_data      = pc + dec.imm_u;
         end
         CLS_JAL: begin
            res.rd_index     = dec.rd;
            wr_en            = 1'b1;
            wr_data          = pc_plus4;
            res.next_pc      = pc + dec.imm_j;
            res.branch_taken = 1'b1;
         end
         CLS_JALR: begin
            res.rd_index     = dec.rd;
            wr_en            = 1'b1;
            wr_data          = pc_plus4;
            res.next_pc      = (rs1_value + dec.imm_i) & ~XLEN'(1);
            res.branch_taken = 1'b1;
         end
         CLS_BRANCH: begin
            if (cond) begin
               res.next_pc      = pc + dec.imm_b;
               res.branch_taken = 1'b1;
            end
         end
         CLS_LOAD: begin
            res.rd_index  = dec.rd;
            wr_en         = 1'b1;
            res.mem_kind  = MEM_LOAD;
            res.mem_width = dec.funct3;
            res.mem_addr  = rs1_value + dec.imm_i;
         end
         CLS_STORE: begin
            res.mem_kind   = MEM_STORE;
            res.mem_width  = dec.funct3;
            res.mem_addr   = rs1_value + dec.imm_s;
            res.store_data = rs2_value;
         end
         CLS_OPIMM, CLS_OP: begin
            res.rd_index = dec.rd;
            wr_en        = 1'b1;
            wr_data      = alu_out;
         end
         default: begin
            res.illegal = 1'b1;
         end
      endcase
      res.rd_write = wr_en && (res.rd_index != '0);
      res.rd_data  = res.rd_write ? wr_data : '0;
   end

endmodule

[design/rv32i_decode_execute.sv]
// Top level of the RV32I decode and execute block: input register, execute logic, result register.
// Depends on rvde_pkg and rvde_exec.
//
//   Channel   Direction  Beat contents (tdata, low bits first)
//   req_*     in         instr, pc, rs1_value, rs2_value (128 bits)
//   rsp_*     out        rd_index, rd_write, rd_data, next_pc, branch_taken, mem_kind,
//                        mem_width, mem_addr, store_data, illegal, zero fill (144 bits)
//
// One instruction per cycle is accepted unless stalled; it flows via input, then result register.
// The critical path is one 32-bit adder or shifter plus result selection.
// Reset is synchronous and clears only the two valid flags.
// A stalled response holds in the result register while the input register still takes
// one more beat; after that req_tready follows rsp_tready.
module rv32i_decode_execute
   import rvde_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // instr, pc, rs1_value, rs2_value
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata    // rd_index, rd_write, rd_data, next_pc, branch_taken,
                                     // mem_kind, mem_width, mem_addr, store_data, illegal
);

   logic            in_valid_ff;
   logic            in_valid_in;
   logic [XLEN-1:0] instr_ff;
   logic [XLEN-1:0] pc_ff;
   logic [XLEN-1:0] rs1_ff;
   logic [XLEN-1:0] rs2_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   result_type      out_ff;
   result_type      out_in;
   logic            out_free;
   logic            advance;
   logic            req_take;

   // Handshake control.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take ? 1'b1 : (out_free ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register captures the request beat.
   always_ff @(posedge clock) begin
      if (req_take) begin
         instr_ff <= req_tdata[31:0];
         pc_ff    <= req_tdata[63:32];
         rs1_ff   <= req_tdata[95:64];
         rs2_ff   <= req_tdata[127:96];
      end
   end

   rvde_exec u_exec (
      .instr     (instr_ff),
      .pc        (pc_ff),
      .rs1_value (rs1_ff),
      .rs2_value (rs2_ff),
      .res       (out_in)
   );

   // Result register loads when the stage moves forward.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff};

endmodule
